/* rtl/vb_pkg.sv */
// ----------------------------------------------------------------------------
// vb_pkg
// Shared types, register indexes and helpers for the planar video blitter.
// ----------------------------------------------------------------------------
package vb_pkg;

  typedef enum logic [2:0] {
    CMD_REG_RD    = 3'd0,
    CMD_REG_WR    = 3'd1,
    CMD_BLIT      = 3'd2,
    CMD_VRAM_RD   = 3'd3,
    CMD_VRAM_WR   = 3'd4,
    CMD_PLANE_SEL = 3'd5,
    CMD_VID_CTL   = 3'd6,
    CMD_ROM_LOAD  = 3'd7
  } cmd_e;

  localparam logic [3:0] R_ADDR_LO = 4'd0;
  localparam logic [3:0] R_ADDR_HI = 4'd1;
  localparam logic [3:0] R_XPOS    = 4'd2;
  localparam logic [3:0] R_YPOS    = 4'd3;
  localparam logic [3:0] R_WIDTH   = 4'd4;
  localparam logic [3:0] R_HEIGHT  = 4'd5;
  localparam logic [3:0] R_GFX     = 4'd6;
  localparam logic [3:0] R_MASK    = 4'd7;
  localparam logic [3:0] R_ATTR    = 4'd8;
  localparam logic [3:0] NUM_REGS  = 4'd9;

  localparam logic [15:0] XLAT_BASE = 16'hC000;
  localparam logic [15:0] ROM_BASE  = 16'h2000;
  localparam logic [15:0] ROM_SPAN  = 16'h6000;
  localparam logic [12:0] OFF_MASK  = 13'h1FFF;
  localparam logic [15:0] OR_MASK   = 16'hFF00;
  localparam logic [7:0]  MASK_LEFT = 8'h80;
  localparam logic [7:0]  MASK_RGT  = 8'h01;

  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  reg_index;
    logic [12:0] vram_offset;
    logic [14:0] rom_addr;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic ready;
    logic clearing;
  } back_stat_t;

  // v mod m for m >= 1024 and v < 8192: the quotient fits in three bits,
  // so three restoring steps (4m, 2m, m) are enough
  function automatic logic [12:0] mod13(input logic [12:0] v, input logic [13:0] m);
    logic [15:0] r;
    r = {3'b000, v};
    if (r >= {m, 2'b00}) r = r - {m, 2'b00};
    if (r >= {1'b0, m, 1'b0}) r = r - {1'b0, m, 1'b0};
    if (r >= {2'b00, m}) r = r - {2'b00, m};
    return r[12:0];
  endfunction

endpackage

/* rtl/vb_front.sv */
// ----------------------------------------------------------------------------
// vb_front
// Command intake: accepts transactions and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module vb_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic [3:0]         reg_index,
  input  logic [12:0]        vram_offset,
  input  logic [14:0]        rom_addr,
  input  logic [7:0]         data_in,
  input  vb_pkg::back_stat_t stat,
  output logic               head_valid,
  output vb_pkg::item_t      head
);
  import vb_pkg::*;

  item_t       q [2];
  logic        wptr, rptr;
  logic [1:0]  count;
  logic        push, pop;

  assign busy       = (count == 2'd2) || stat.clearing;
  assign push       = start && !busy;
  assign head_valid = (count != 2'd0);
  assign pop        = head_valid && stat.ready;
  assign head       = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr].cmd         <= cmd_e'(cmd);
      q[wptr].reg_index   <= reg_index;
      q[wptr].vram_offset <= vram_offset;
      q[wptr].rom_addr    <= rom_addr;
      q[wptr].data        <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/vb_back.sv */
// ----------------------------------------------------------------------------
// vb_back
// Execution engine: registers, image RAM, graphics ROM, bitplanes and blits.
// ----------------------------------------------------------------------------
module vb_back #(
  parameter int PLANE_BYTES     = 8192,
  parameter int IMAGE_RAM_BYTES = 8192,
  parameter int ROM_BYTES       = 24576
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  vb_pkg::item_t      head,
  output vb_pkg::back_stat_t stat,
  output logic               done,
  output logic [7:0]         read_data
);
  import vb_pkg::*;

  localparam int PAW = $clog2(PLANE_BYTES);
  localparam int IAW = $clog2(IMAGE_RAM_BYTES);
  localparam int RAW = $clog2(ROM_BYTES);

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_EXEC     = 10'b0000000100,
    S_IMG_WAIT = 10'b0000001000,
    S_VRD_WAIT = 10'b0000010000,
    S_BSETUP   = 10'b0000100000,
    S_BFETCH   = 10'b0001000000,
    S_BMOD1    = 10'b0010000000,
    S_BMOD2    = 10'b0100000000,
    S_SPARE    = 10'b1000000000
  } state_t;

  state_t      state;
  item_t       it;
  logic [7:0]  regs [9];
  logic [3:0]  write_planes;
  logic [1:0]  read_plane;
  logic        working_page;
  logic [PAW-1:0] clr;

  logic [7:0]  pic_ram [IMAGE_RAM_BYTES];
  logic [7:0]  gfx_rom   [ROM_BYTES];
  logic [7:0]  vram      [8][PLANE_BYTES];
  logic [7:0]  vrd_q     [8];
  logic [7:0]  img_ram_q, rom_q;
  logic        hit_ram_q, hit_rom_q;

  // blit state
  logic [4:0]  xb;
  logic [2:0]  sh;
  logic [7:0]  y, bi, br;
  logic        dy_up, mode;
  logic [7:0]  cur;
  logic [12:0] off_q;

  // datapath controls
  logic [15:0] img_addr, rom_off;
  logic        rom_hit, adv;
  logic [IAW-1:0] iram_raddr;
  logic [RAW-1:0] rom_raddr;
  logic        iram_we, rom_we;
  logic [7:0]  v_we;
  logic [PAW-1:0] v_waddr, v_raddr;
  logic [7:0]  v_wdata;
  logic [7:0]  plane_rd, img_data, cur_eff, hi, lo;
  logic        img_hit;
  logic [15:0] xlat;
  logic [7:0]  pix_mask, reg_val;
  logic [12:0] boff, boff1;
  logic [7:0]  bx;
  logic [15:0] hmask;

  assign stat.ready    = (state == S_IDLE);
  assign stat.clearing = (state == S_CLEAR);

  assign img_addr   = {regs[R_ADDR_HI], regs[R_ADDR_LO]};
  assign rom_off    = img_addr - ROM_BASE;
  assign rom_hit    = (img_addr >= ROM_BASE) && (rom_off < ROM_SPAN) &&
                      (rom_off < 16'(ROM_BYTES));
  assign rom_raddr  = rom_hit ? rom_off[RAW-1:0] : '0;
  assign iram_raddr = IAW'(mod13(img_addr[12:0], 14'(IMAGE_RAM_BYTES)));
  assign img_hit    = hit_ram_q || hit_rom_q;
  assign img_data   = hit_ram_q ? img_ram_q : rom_q;
  assign plane_rd   = vrd_q[{working_page, read_plane}];

  assign xlat     = XLAT_BASE | ({regs[R_YPOS], regs[R_XPOS]} >> 3);
  assign pix_mask = regs[R_ATTR][0] ? (MASK_RGT << regs[R_XPOS][2:0])
                                    : (MASK_LEFT >> regs[R_XPOS][2:0]);

  always_comb begin
    reg_val = 8'd0;
    if (it.reg_index < NUM_REGS) begin
      case (it.reg_index)
        R_XPOS:  reg_val = xlat[7:0];
        R_YPOS:  reg_val = xlat[15:8];
        R_MASK:  reg_val = pix_mask;
        default: reg_val = regs[it.reg_index];
      endcase
    end
  end

  assign bx    = regs[R_XPOS] - {regs[R_WIDTH][4:0], 3'b000};
  assign boff  = 13'({y, 5'b00000} + {8'd0, xb} + {5'd0, bi});
  assign boff1 = (off_q + 13'd1) & OFF_MASK;
  assign cur_eff = img_hit ? img_data : cur;
  assign hi    = cur_eff >> sh;
  assign lo    = 8'(({8'd0, cur} << (4'd8 - {1'b0, sh})));
  assign hmask = OR_MASK >> sh;

  always_comb begin
    adv      = 1'b0;
    iram_we  = 1'b0;
    rom_we   = 1'b0;
    v_we     = 8'd0;
    v_waddr  = '0;
    v_raddr  = '0;
    v_wdata  = 8'd0;
    unique case (state)
      S_CLEAR: begin
        v_we    = 8'hFF;
        v_waddr = clr;
      end
      S_EXEC: begin
        case (it.cmd)
          CMD_REG_RD: adv = (it.reg_index == R_GFX);
          CMD_REG_WR: begin
            adv     = (it.reg_index == R_GFX);
            iram_we = (it.reg_index == R_GFX) && (img_addr < ROM_BASE);
          end
          CMD_VRAM_RD: v_raddr = PAW'(mod13(it.vram_offset, 14'(PLANE_BYTES)));
          CMD_VRAM_WR: begin
            v_waddr = PAW'(mod13(it.vram_offset, 14'(PLANE_BYTES)));
            v_wdata = it.data;
            v_we    = working_page ? {write_planes, 4'd0} : {4'd0, write_planes};
          end
          CMD_ROM_LOAD: rom_we = ({1'b0, it.rom_addr} < 16'(ROM_BYTES));
          default: ;
        endcase
      end
      S_BFETCH: begin
        adv     = 1'b1;
        v_raddr = PAW'(mod13(boff, 14'(PLANE_BYTES)));
      end
      S_BMOD1: begin
        v_waddr = PAW'(mod13(off_q, 14'(PLANE_BYTES)));
        v_wdata = mode ? (plane_rd ^ hi) : ((plane_rd & hmask[7:0]) | hi);
        v_we    = working_page ? {write_planes, 4'd0} : {4'd0, write_planes};
        v_raddr = PAW'(mod13(boff1, 14'(PLANE_BYTES)));
      end
      S_BMOD2: begin
        v_waddr = PAW'(mod13(off_q, 14'(PLANE_BYTES)));
        v_wdata = mode ? (plane_rd ^ lo) : ((plane_rd & (8'hFF >> sh)) | lo);
        v_we    = working_page ? {write_planes, 4'd0} : {4'd0, write_planes};
      end
      default: ;
    endcase
  end

  // image stores
  always_ff @(posedge clk) begin
    if (iram_we) pic_ram[iram_raddr] <= it.data;
    img_ram_q <= pic_ram[iram_raddr];
    hit_ram_q <= (img_addr < ROM_BASE);
  end

  always_ff @(posedge clk) begin
    if (rom_we) gfx_rom[it.rom_addr[RAW-1:0]] <= it.data;
    rom_q     <= gfx_rom[rom_raddr];
    hit_rom_q <= rom_hit;
  end

  // bitplanes: one RAM per plane, both pages
  always_ff @(posedge clk) begin
    for (int p = 0; p < 8; p++) begin
      if (v_we[p]) vram[p][v_waddr] <= v_wdata;
      vrd_q[p] <= vram[p][v_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      done         <= 1'b0;
      read_data    <= 8'd0;
      write_planes <= 4'd0;
      read_plane   <= 2'd0;
      working_page <= 1'b0;
      for (int k = 0; k < 9; k++) regs[k] <= 8'd0;
    end else begin
      done <= 1'b0;
      if (adv) {regs[R_ADDR_HI], regs[R_ADDR_LO]} <= img_addr + 16'd1;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + PAW'(1);
          if (clr == PAW'(PLANE_BYTES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (head_valid) begin
            it    <= head;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state     <= S_IDLE;
          done      <= 1'b1;
          read_data <= 8'd0;
          case (it.cmd)
            CMD_REG_RD: begin
              if (it.reg_index == R_GFX) begin
                done  <= 1'b0;
                state <= S_IMG_WAIT;
              end else begin
                read_data <= reg_val;
              end
            end
            CMD_REG_WR: begin
              if (it.reg_index < NUM_REGS && it.reg_index != R_GFX)
                regs[it.reg_index] <= it.data;
            end
            CMD_BLIT: begin
              done  <= 1'b0;
              state <= S_BSETUP;
            end
            CMD_VRAM_RD: begin
              done  <= 1'b0;
              state <= S_VRD_WAIT;
            end
            CMD_PLANE_SEL: begin
              write_planes <= it.data[3:0];
              read_plane   <= it.data[5:4];
            end
            CMD_VID_CTL: working_page <= it.data[1];
            default: ;
          endcase
        end
        S_IMG_WAIT: begin
          read_data <= img_hit ? img_data : regs[R_GFX];
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_VRD_WAIT: begin
          read_data <= plane_rd;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_BSETUP: begin
          xb    <= bx[7:3];
          sh    <= bx[2:0];
          dy_up <= regs[R_ATTR][4];
          y     <= regs[R_ATTR][4] ? (regs[R_YPOS] + 8'd7 - regs[R_HEIGHT])
                                   : regs[R_YPOS];
          mode  <= (it.data != 8'd0);
          cur   <= it.data;
          bi    <= 8'd0;
          br    <= 8'd0;
          state <= S_BFETCH;
        end
        S_BFETCH: begin
          off_q <= boff;
          state <= S_BMOD1;
        end
        S_BMOD1: begin
          cur   <= cur_eff;
          off_q <= boff1;
          state <= S_BMOD2;
        end
        S_BMOD2: begin
          state <= S_BFETCH;
          if (bi == regs[R_WIDTH]) begin
            bi <= 8'd0;
            y  <= dy_up ? (y + 8'd1) : (y - 8'd1);
            if (br == regs[R_HEIGHT]) begin
              read_data <= 8'd0;
              done      <= 1'b1;
              state     <= S_IDLE;
            end else begin
              br <= br + 8'd1;
            end
          end else begin
            bi <= bi + 8'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/planar_video_blitter.sv */
// ----------------------------------------------------------------------------
// planar_video_blitter
// Bus-access blitter with image RAM, graphics ROM and two pages of bitplanes.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single result
// appears on read_data with done high for one cycle, and the receiver cannot
// stall it. Up to two transactions queue ahead of the engine. Register,
// plane-select and ROM-load commands finish in the execute state; reads
// through image RAM/ROM or a bitplane add a wait state for the registered
// memory read. A blit does, for each of its (width+1)*(height+1) bytes, one
// image fetch and two read-modify-writes through the bitplane RAMs. After
// reset the bitplanes are zeroed while busy stays high.
module planar_video_blitter #(
  parameter int PLANE_BYTES     = 8192,
  parameter int IMAGE_RAM_BYTES = 8192,
  parameter int ROM_BYTES       = 24576
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [3:0]  reg_index,
  input  logic [12:0] vram_offset,
  input  logic [14:0] rom_addr,
  input  logic [7:0]  data_in,
  output logic        done,
  output logic [7:0]  read_data
);
  import vb_pkg::*;

  back_stat_t stat;
  item_t      head;
  logic       head_valid;

  vb_front u_front (
    .clk, .rst, .start, .busy, .cmd, .reg_index, .vram_offset, .rom_addr,
    .data_in, .stat, .head_valid, .head
  );

  vb_back #(
    .PLANE_BYTES(PLANE_BYTES),
    .IMAGE_RAM_BYTES(IMAGE_RAM_BYTES),
    .ROM_BYTES(ROM_BYTES)
  ) u_back (
    .clk, .rst, .head_valid, .head, .stat, .done, .read_data
  );

endmodule
